### rtl/ffga_pkg.sv
// ----------------------------------------------------------------------------
// ffga_pkg
// Types and constants shared by the first-fit guarded allocator.
// ----------------------------------------------------------------------------
package ffga_pkg;

    localparam int unsigned POOL_WORDS_DEF = 4096;
    localparam int unsigned OFF_W          = 34;   // offset width, carries sums
    localparam logic [31:0] GUARD_WORD     = 32'hDEADBEEF;
    localparam logic [14:0] POOL_BYTES_RST = 15'd16384;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_FIT     = 3'd1;
    localparam logic [2:0] ST_RANGE_BAD  = 3'd2;
    localparam logic [2:0] ST_FRONT_BAD  = 3'd3;
    localparam logic [2:0] ST_REAR_BAD   = 3'd4;
    localparam logic [2:0] ST_BAD_ACCESS = 3'd5;

    localparam logic REG_POOL_BASE  = 1'b0;
    localparam logic REG_POOL_BYTES = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [14:0] request_size;
        logic [31:0] user_address;
        logic [31:0] write_data;
    } t_in;

    typedef struct packed {
        logic [31:0] result_address;
        logic [31:0] read_data;
        logic [2:0]  status;
    } t_out;

endpackage

### rtl/first_fit_guarded_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_guarded_allocator_core
// First-fit free-list allocator over an on-chip word pool, with guard words,
// address-ordered free list and coalescing on free.
//
//   channel | direction | handshake               | beat
//   --------+-----------+-------------------------+---------------------
//   in      | input     | i_in_valid / o_in_stall | ffga_pkg::t_in
//   out     | output    | o_out_valid/ i_out_stall| ffga_pkg::t_out
//   cfg     | input     | APB psel/penable        | pool_base, pool_bytes
//
// One item at a time through a sequencer around one pool RAM with separate
// read and write ports (one read, one write per cycle, registered read data).
// Read/write ops check the address and then access one word. Allocate walks
// the list first-fit and makes 7 writes on a split (3 when the block is taken
// whole). Free checks the range and both guards, walks the list and merges.
// Reset and each pool_bytes write run a clearing pass over every pool word
// that rebuilds the header; input stalls meanwhile. A finished result holds
// in the output register until taken; the next beat is accepted meanwhile.
// ----------------------------------------------------------------------------
module first_fit_guarded_allocator_core #(
    parameter int unsigned POOL_WORDS = ffga_pkg::POOL_WORDS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  ffga_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output ffga_pkg::t_out o_out_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam int unsigned AW  = $clog2(POOL_WORDS);
    localparam int unsigned OW  = ffga_pkg::OFF_W;
    localparam logic [OW-1:0] CAP = OW'(POOL_WORDS * 4) & ~OW'(7);
    localparam logic [AW:0]   N_MAX = (AW+1)'(POOL_WORDS);
    localparam logic [AW:0]   CLR_LAST = (AW+1)'(POOL_WORDS - 1);

    typedef enum logic [5:0] {
        S_IDLE, S_ACHK, S_AS, S_ANX, S_AW1, S_AW2, S_AW3, S_AW4, S_AW5, S_AWH,
        S_AG1, S_AG2, S_FCHK, S_FS, S_FG1, S_FG2, S_FH, S_FWALK, S_FWL,
        S_FINS, S_FINS2, S_FM1, S_FM2, S_FM3, S_FM4, S_FP0, S_FP1, S_FP2,
        S_FP3, S_RW, S_RD1, S_FIN, S_AH
    } t_state;

    t_state r_state;

    logic [31:0]   r_base, r_init_base;
    logic [14:0]   r_bytes;
    logic          r_clr_busy;
    logic [AW:0]   r_clr_cnt;

    logic [1:0]    r_op;
    logic [31:0]   r_data;
    logic [31:0]   r_o, r_s, r_nx, r_ps, r_lnk, r_prev, r_need, r_co, r_blk;
    logic          r_have;
    logic [AW:0]   r_n;
    logic [31:0]   r_res, r_rdv;
    logic [2:0]    r_st;

    logic          r_out_valid;
    ffga_pkg::t_out r_out;

    logic [31:0]   mem [POOL_WORDS];
    logic [31:0]   r_q;
    logic          r_rd_ok;

    logic [OW-1:0] pool_e;
    logic [31:0]   rdata;
    logic [OW-1:0] rd_off, w_off;
    logic          w_en;
    logic [31:0]   w_val;
    logic          mem_we;
    logic [AW-1:0] mem_widx;
    logic [31:0]   mem_wd, clr_val;
    logic [31:0]   lo_off;
    logic          lo_ok;
    logic          cfg_wr;
    logic          in_acc;

    function automatic logic [OW-1:0] ext(input logic [31:0] v);
        ext = {{(OW-32){1'b0}}, v};
    endfunction

    // effective pool end
    always_comb begin
        logic [OW-1:0] e;
        e = {{(OW-15){1'b0}}, r_bytes} & ~OW'(7);
        pool_e = (e < CAP) ? e : CAP;
    end

    assign rdata = r_rd_ok ? r_q : 32'd0;

    // shared link check on r_lnk
    assign lo_off = r_lnk - r_base;
    assign lo_ok  = (r_lnk != 32'd0) && (lo_off[2:0] == 3'd0) && (lo_off >= 32'd8)
                    && (ext(lo_off) + OW'(8) <= pool_e);

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ffga_pkg::REG_POOL_BYTES) ? {17'd0, r_bytes} : r_base;

    assign o_in_stall  = (r_state != S_IDLE) || r_clr_busy;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // memory port selection per state
    always_comb begin
        rd_off = '0;
        w_en   = 1'b0;
        w_off  = '0;
        w_val  = '0;
        case (r_state)
            S_IDLE:  rd_off = OW'(4);
            S_ACHK:  rd_off = ext(lo_off);
            S_AS:    rd_off = ext(r_o) + OW'(4);
            S_AW1: begin
                w_en = 1'b1; w_off = ext(r_o) + ext(r_need); w_val = r_s - r_need;
            end
            S_AW2: begin
                w_en = 1'b1; w_off = ext(r_o) + ext(r_need) + OW'(4); w_val = r_nx;
            end
            S_AW3: begin
                w_en = 1'b1; w_off = ext(r_o); w_val = r_need;
            end
            S_AW4: begin
                w_en = 1'b1; w_off = ext(r_o) + OW'(4); w_val = 32'd0;
            end
            S_AW5: begin
                w_en = 1'b1; w_off = ext(r_prev); w_val = r_lnk + r_need;
            end
            S_AWH: begin
                w_en = 1'b1; w_off = ext(r_prev); w_val = r_nx;
            end
            S_AG1: begin
                w_en = 1'b1; w_off = ext(r_o) + OW'(8); w_val = ffga_pkg::GUARD_WORD;
            end
            S_AG2: begin
                w_en = 1'b1; w_off = ext(r_o) + ext(r_blk) - OW'(4);
                w_val = ffga_pkg::GUARD_WORD;
            end
            S_FCHK:  rd_off = ext(r_o);
            S_FS:    rd_off = ext(r_o) + OW'(8);
            S_FG1:   rd_off = ext(r_o) + ext(r_s) - OW'(4);
            S_FG2:   rd_off = OW'(4);
            S_FWALK: rd_off = ext(lo_off) + OW'(4);
            S_FINS: begin
                w_en = 1'b1; w_off = ext(r_o) + OW'(4); w_val = lo_ok ? r_lnk : 32'd0;
            end
            S_FINS2: begin
                w_en = 1'b1; w_off = ext(r_prev); w_val = r_base + r_o;
            end
            S_FM1:   rd_off = ext(r_co);
            S_FM2:   rd_off = ext(r_co) + OW'(4);
            S_FM3: begin
                w_en = 1'b1; w_off = ext(r_o); w_val = r_s;
            end
            S_FM4: begin
                w_en = 1'b1; w_off = ext(r_o) + OW'(4); w_val = r_nx;
            end
            S_FP0:   rd_off = ext(r_prev) - OW'(4);
            S_FP1:   rd_off = ext(r_o) + OW'(4);
            S_FP2: begin
                w_en  = (ext(r_prev) - OW'(4) + ext(r_ps)) == ext(r_o);
                w_off = ext(r_prev) - OW'(4);
                w_val = r_ps + r_s;
            end
            S_FP3: begin
                w_en = 1'b1; w_off = ext(r_prev); w_val = r_nx;
            end
            S_RW: begin
                rd_off = ext(r_o);
                w_en   = (r_op == ffga_pkg::OP_WRITE) && (r_o[1:0] == 2'd0);
                w_off  = ext(r_o);
                w_val  = r_data;
            end
            default: ;
        endcase
    end

    // clearing pass rebuilds header and one free block
    always_comb begin
        logic [AW:0] a;
        a = r_clr_cnt;
        clr_val = 32'd0;
        if (pool_e >= OW'(16)) begin
            if (a == (AW+1)'(0))      clr_val = pool_e[31:0];
            else if (a == (AW+1)'(1)) clr_val = r_init_base + 32'd8;
            else if (a == (AW+1)'(2)) clr_val = pool_e[31:0] - 32'd8;
        end
    end

    always_comb begin
        if (r_clr_busy) begin
            mem_we   = 1'b1;
            mem_widx = r_clr_cnt[AW-1:0];
            mem_wd   = clr_val;
        end else begin
            mem_we   = w_en && (w_off < pool_e);
            mem_widx = w_off[AW+1:2];
            mem_wd   = w_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_widx] <= mem_wd;
        end
        r_q     <= mem[rd_off[AW+1:2]];
        r_rd_ok <= rd_off < pool_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= 32'd0;
            r_init_base <= 32'd0;
            r_bytes     <= ffga_pkg::POOL_BYTES_RST;
            r_clr_busy  <= 1'b1;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // S_FIN sets valid itself when the held beat is taken
            if (r_out_valid && !i_out_stall && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end

            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + (AW+1)'(1);
                if (r_clr_cnt == CLR_LAST) begin
                    r_clr_busy <= 1'b0;
                end
            end

            if (cfg_wr) begin
                if (paddr[2] == ffga_pkg::REG_POOL_BASE) begin
                    r_base <= pwdata;
                end else begin
                    r_bytes     <= pwdata[14:0];
                    r_clr_busy  <= 1'b1;
                    r_clr_cnt   <= '0;
                    r_init_base <= r_base;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op   <= i_in_data.operation;
                        r_data <= i_in_data.write_data;
                        r_res  <= 32'd0;
                        r_rdv  <= 32'd0;
                        r_st   <= ffga_pkg::ST_OK;
                        r_n    <= '0;
                        r_prev <= 32'd4;
                        r_need <= ((32'(i_in_data.request_size) + 32'd7) & ~32'd7) + 32'd16;
                        case (i_in_data.operation)
                            ffga_pkg::OP_ALLOC: begin
                                r_state <= S_AH;
                            end
                            ffga_pkg::OP_FREE: begin
                                r_o     <= i_in_data.user_address - r_base - 32'd12;
                                r_state <= S_FCHK;
                            end
                            default: begin
                                r_o     <= i_in_data.user_address - r_base;
                                r_state <= S_RW;
                            end
                        endcase
                    end
                end
                S_AH: begin
                    r_lnk   <= rdata;
                    r_state <= S_ACHK;
                end
                S_ACHK: begin
                    if (r_n == N_MAX || !lo_ok) begin
                        r_st    <= ffga_pkg::ST_NO_FIT;
                        r_state <= S_FIN;
                    end else begin
                        r_o     <= lo_off;
                        r_state <= S_AS;
                    end
                end
                S_AS: begin
                    r_s     <= rdata;
                    r_state <= S_ANX;
                end
                S_ANX: begin
                    r_nx <= rdata;
                    if (r_s >= r_need) begin
                        if ({1'b0, r_s} >= {1'b0, r_need} + 33'd16) begin
                            r_blk   <= r_need;
                            r_state <= S_AW1;
                        end else begin
                            r_blk   <= r_s;
                            r_state <= S_AWH;
                        end
                    end else begin
                        r_prev  <= r_o + 32'd4;
                        r_lnk   <= rdata;
                        r_n     <= r_n + (AW+1)'(1);
                        r_state <= S_ACHK;
                    end
                end
                S_AW1: r_state <= S_AW2;
                S_AW2: r_state <= S_AW3;
                S_AW3: r_state <= S_AW4;
                S_AW4: r_state <= S_AW5;
                S_AW5: r_state <= S_AG1;
                S_AWH: r_state <= S_AG1;
                S_AG1: r_state <= S_AG2;
                S_AG2: begin
                    r_res   <= r_lnk + 32'd12;
                    r_state <= S_FIN;
                end
                S_FCHK: begin
                    if (r_o[2:0] != 3'd0 || r_o < 32'd8 || ext(r_o) + OW'(16) > pool_e) begin
                        r_st    <= ffga_pkg::ST_RANGE_BAD;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_FS;
                    end
                end
                S_FS: begin
                    r_s <= rdata;
                    if (rdata < 32'd16 || rdata[2:0] != 3'd0
                            || ext(r_o) + ext(rdata) > pool_e) begin
                        r_st    <= ffga_pkg::ST_RANGE_BAD;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_FG1;
                    end
                end
                S_FG1: begin
                    if (rdata != ffga_pkg::GUARD_WORD) begin
                        r_st    <= ffga_pkg::ST_FRONT_BAD;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_FG2;
                    end
                end
                S_FG2: begin
                    if (rdata != ffga_pkg::GUARD_WORD) begin
                        r_st    <= ffga_pkg::ST_REAR_BAD;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_FH;
                    end
                end
                S_FH: begin
                    r_lnk   <= rdata;
                    r_state <= S_FWALK;
                end
                S_FWALK: begin
                    if (r_n == N_MAX || !lo_ok || lo_off >= r_o) begin
                        r_state <= S_FINS;
                    end else begin
                        r_prev  <= lo_off + 32'd4;
                        r_n     <= r_n + (AW+1)'(1);
                        r_state <= S_FWL;
                    end
                end
                S_FWL: begin
                    r_lnk   <= rdata;
                    r_state <= S_FWALK;
                end
                S_FINS: begin
                    r_have  <= lo_ok;
                    r_co    <= lo_off;
                    r_state <= S_FINS2;
                end
                S_FINS2: begin
                    if (r_have && ext(r_o) + ext(r_s) == ext(r_co)) begin
                        r_state <= S_FM1;
                    end else begin
                        r_state <= S_FP0;
                    end
                end
                S_FM1: r_state <= S_FM2;
                S_FM2: begin
                    r_s     <= r_s + rdata;
                    r_state <= S_FM3;
                end
                S_FM3: begin
                    r_nx    <= rdata;
                    r_state <= S_FM4;
                end
                S_FM4: r_state <= S_FP0;
                S_FP0: begin
                    r_state <= (r_prev != 32'd4) ? S_FP1 : S_FIN;
                end
                S_FP1: begin
                    r_ps    <= rdata;
                    r_state <= S_FP2;
                end
                S_FP2: begin
                    r_nx    <= rdata;
                    r_state <= w_en ? S_FP3 : S_FIN;
                end
                S_FP3: r_state <= S_FIN;
                S_RW: begin
                    if (r_o[1:0] != 2'd0 || ext(r_o) >= pool_e) begin
                        r_st    <= ffga_pkg::ST_BAD_ACCESS;
                        r_state <= S_FIN;
                    end else if (r_op == ffga_pkg::OP_READ) begin
                        r_state <= S_RD1;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_RD1: begin
                    r_rdv   <= rdata;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid          <= 1'b1;
                        r_out.result_address <= r_res;
                        r_out.read_data      <= r_rdv;
                        r_out.status         <= r_st;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the first-fit guarded allocator: a behavioral pool model in
// the testbench predicts every result beat, a checker compares each beat
// taken from the output channel, and named tests cover directed corners,
// register settings, random alloc/free traffic and output back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NWORDS = ffga_pkg::POOL_WORDS_DEF;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_stall;
    ffga_pkg::t_in  i_in_data;
    logic           o_out_valid;
    logic           i_out_stall;
    ffga_pkg::t_out o_out_data;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [2:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    first_fit_guarded_allocator_core dut (.*);

    // allocator model state
    logic [31:0]    pool_mem [NWORDS];
    logic [31:0]    m_base;
    logic [14:0]    m_bytes;
    ffga_pkg::t_out pending_beats [$];
    logic [31:0]    live_blocks [$];
    int             errors;
    int             send_idle_pct;
    int             recv_idle_pct;
    bit             hold_output;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    function automatic longint unsigned pool_end_bytes();
        longint unsigned e;
        longint unsigned cap;
        e   = longint'(m_bytes) & ~64'd7;
        cap = (longint'(NWORDS) * 4) & ~64'd7;
        return (e < cap) ? e : cap;
    endfunction

    function automatic logic [31:0] pool_rd(longint unsigned off);
        if (off < pool_end_bytes()) return pool_mem[off >> 2];
        return 32'd0;
    endfunction

    function automatic void pool_wr(longint unsigned off, logic [31:0] v);
        if (off < pool_end_bytes()) pool_mem[off >> 2] = v;
    endfunction

    function automatic bit link_valid(logic [31:0] lnk, output longint unsigned off);
        logic [31:0] d;
        d   = lnk - m_base;
        off = longint'(d);
        return lnk != 0 && off[2:0] == 0 && off >= 8 && off + 8 <= pool_end_bytes();
    endfunction

    function automatic void pool_rebuild();
        longint unsigned e;
        e = pool_end_bytes();
        foreach (pool_mem[i]) pool_mem[i] = 32'd0;
        if (e >= 16) begin
            pool_wr(0, 32'(e));
            pool_wr(4, m_base + 32'd8);
            pool_wr(8, 32'(e - 8));
            pool_wr(12, 32'd0);
        end
    endfunction

    function automatic logic [31:0] model_alloc(logic [14:0] req);
        logic [31:0] need;
        logic [31:0] lnk;
        logic [31:0] s;
        logic [31:0] nx;
        logic [31:0] blk;
        longint unsigned prev;
        longint unsigned o;
        need = ((32'(req) + 32'd7) & ~32'd7) + 32'd16;
        prev = 4;
        lnk  = pool_rd(4);
        for (int n = 0; n < NWORDS; n++) begin
            if (!link_valid(lnk, o)) return 32'd0;
            s  = pool_rd(o);
            nx = pool_rd(o + 4);
            if (s >= need) begin
                if (longint'(s) >= longint'(need) + 16) begin
                    pool_wr(o + need, s - need);
                    pool_wr(o + need + 4, nx);
                    pool_wr(o, need);
                    pool_wr(o + 4, 32'd0);
                    pool_wr(prev, lnk + need);
                    blk = need;
                end else begin
                    pool_wr(prev, nx);
                    blk = s;
                end
                pool_wr(o + 8, ffga_pkg::GUARD_WORD);
                pool_wr(o + blk - 4, ffga_pkg::GUARD_WORD);
                return lnk + 32'd12;
            end
            prev = o + 4;
            lnk  = nx;
        end
        return 32'd0;
    endfunction

    function automatic logic [2:0] model_free(logic [31:0] addr);
        longint unsigned e;
        longint unsigned o;
        longint unsigned co;
        longint unsigned prev;
        longint unsigned po;
        logic [31:0] d;
        logic [31:0] s;
        logic [31:0] lnk;
        logic [31:0] ps;
        bit          have;
        e    = pool_end_bytes();
        d    = addr - m_base - 32'd12;
        o    = longint'(d);
        prev = 4;
        if (o[2:0] != 0 || o < 8 || o + 16 > e) return ffga_pkg::ST_RANGE_BAD;
        s = pool_rd(o);
        if (s < 16 || s[2:0] != 0 || o + s > e) return ffga_pkg::ST_RANGE_BAD;
        if (pool_rd(o + 8) != ffga_pkg::GUARD_WORD) return ffga_pkg::ST_FRONT_BAD;
        if (pool_rd(o + s - 4) != ffga_pkg::GUARD_WORD) return ffga_pkg::ST_REAR_BAD;
        lnk = pool_rd(4);
        for (int n = 0; n < NWORDS; n++) begin
            if (!link_valid(lnk, co) || co >= o) break;
            prev = co + 4;
            lnk  = pool_rd(co + 4);
        end
        have = link_valid(lnk, co);
        pool_wr(o + 4, have ? lnk : 32'd0);
        pool_wr(prev, m_base + 32'(o));
        if (have && o + s == co) begin
            s = s + pool_rd(co);
            pool_wr(o, s);
            pool_wr(o + 4, pool_rd(co + 4));
        end
        if (prev != 4) begin
            po = prev - 4;
            ps = pool_rd(po);
            if (po + ps == o) begin
                pool_wr(po, ps + s);
                pool_wr(po + 4, pool_rd(o + 4));
            end
        end
        return ffga_pkg::ST_OK;
    endfunction

    function automatic ffga_pkg::t_out predict_beat(ffga_pkg::t_in it);
        ffga_pkg::t_out r;
        logic [31:0] d;
        longint unsigned off;
        r = '0;
        case (it.operation)
            ffga_pkg::OP_ALLOC: begin
                r.result_address = model_alloc(it.request_size);
                r.status = (r.result_address != 0) ? ffga_pkg::ST_OK : ffga_pkg::ST_NO_FIT;
            end
            ffga_pkg::OP_FREE: r.status = model_free(it.user_address);
            default: begin
                d   = it.user_address - m_base;
                off = longint'(d);
                if (off[1:0] != 0 || off >= pool_end_bytes()) begin
                    r.status = ffga_pkg::ST_BAD_ACCESS;
                end else if (it.operation == ffga_pkg::OP_WRITE) begin
                    pool_wr(off, it.write_data);
                end else begin
                    r.read_data = pool_rd(off);
                end
            end
        endcase
        return r;
    endfunction

    // send one beat; the prediction is queued when it is accepted.
    // valid stays up between beats unless the sender idles.
    task automatic send_item(ffga_pkg::t_in it);
        ffga_pkg::t_out r;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        r = predict_beat(it);
        pending_beats.push_back(r);
        if (it.operation == ffga_pkg::OP_ALLOC && r.status == ffga_pkg::ST_OK)
            live_blocks.push_back(r.result_address);
    endtask

    task automatic send_op(logic [1:0] op, logic [14:0] sz, logic [31:0] addr,
                           logic [31:0] wd);
        ffga_pkg::t_in it;
        it.operation    = op;
        it.request_size = sz;
        it.user_address = addr;
        it.write_data   = wd;
        send_item(it);
    endtask

    // output stall and checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_beats.size() == 0) begin
                $display("%0t unexpected beat, actual %h", $realtime, o_out_data);
                errors++;
            end else begin
                ffga_pkg::t_out exp_b;
                exp_b = pending_beats.pop_front();
                if (o_out_data.result_address !== exp_b.result_address) begin
                    $display("%0t result_address expected %h actual %h", $realtime,
                             exp_b.result_address, o_out_data.result_address);
                    errors++;
                end
                if (o_out_data.read_data !== exp_b.read_data) begin
                    $display("%0t read_data expected %h actual %h", $realtime,
                             exp_b.read_data, o_out_data.read_data);
                    errors++;
                end
                if (o_out_data.status !== exp_b.status) begin
                    $display("%0t status expected %0d actual %0d", $realtime,
                             exp_b.status, o_out_data.status);
                    errors++;
                end
            end
        end
        i_out_stall <= hold_output || ($urandom_range(99) < recv_idle_pct);
    end

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        // wait out any clearing pass and let in-flight work settle
        repeat (NWORDS + 200) @(posedge i_clk);
    endtask

    task automatic reg_write(logic idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == ffga_pkg::REG_POOL_BASE) begin
            m_base = v;
        end else begin
            m_bytes = v[14:0];
            pool_rebuild();
        end
    endtask

    task automatic free_one_live(bit corrupt);
        int k;
        logic [31:0] a;
        if (live_blocks.size() == 0) return;
        k = $urandom_range(live_blocks.size() - 1);
        a = live_blocks[k];
        live_blocks.delete(k);
        if (corrupt) send_op(ffga_pkg::OP_WRITE, 0, a - 4, $urandom);
        send_op(ffga_pkg::OP_FREE, 0, a, 0);
    endtask

    task automatic test_directed();
        send_op(ffga_pkg::OP_ALLOC, 15'd0, 0, 0);
        send_op(ffga_pkg::OP_ALLOC, 15'd1, 0, 0);
        send_op(ffga_pkg::OP_ALLOC, 15'd16384, 0, 0);
        send_op(ffga_pkg::OP_ALLOC, 15'h7FFF, 0, 0);
        send_op(ffga_pkg::OP_ALLOC, 15'd16336, 0, 0);
        send_op(ffga_pkg::OP_WRITE, 0, 32'd20, 32'hFFFF_FFFF);
        send_op(ffga_pkg::OP_READ, 0, 32'd20, 0);
        send_op(ffga_pkg::OP_READ, 0, 32'd22, 0);
        send_op(ffga_pkg::OP_WRITE, 0, 32'd16384, 32'h1234_5678);
        send_op(ffga_pkg::OP_READ, 0, 32'hFFFF_FFFC, 0);
        send_op(ffga_pkg::OP_FREE, 0, 32'd0, 0);
        send_op(ffga_pkg::OP_FREE, 0, 32'hFFFF_FFFF, 0);
        send_op(ffga_pkg::OP_FREE, 0, 32'd13, 0);
        // rear guard damage, then front guard damage (first block is 16 bytes)
        if (live_blocks.size() != 0) begin
            logic [31:0] a;
            a = live_blocks.pop_front();
            send_op(ffga_pkg::OP_WRITE, 0, a, 32'h0);
            send_op(ffga_pkg::OP_FREE, 0, a, 0);
            send_op(ffga_pkg::OP_WRITE, 0, a - 4, 32'h0);
            send_op(ffga_pkg::OP_FREE, 0, a, 0);
        end
        // double free and merges on both sides
        while (live_blocks.size() != 0) free_one_live(0);
        send_op(ffga_pkg::OP_ALLOC, 15'd40, 0, 0);
        send_op(ffga_pkg::OP_ALLOC, 15'd8, 0, 0);
        send_op(ffga_pkg::OP_ALLOC, 15'd100, 0, 0);
        send_op(ffga_pkg::OP_FREE, 0, live_blocks[0], 0);
        send_op(ffga_pkg::OP_FREE, 0, live_blocks[2], 0);
        send_op(ffga_pkg::OP_FREE, 0, live_blocks[1], 0);
        send_op(ffga_pkg::OP_FREE, 0, live_blocks[1], 0);
        live_blocks.delete();
        wait_drained();
    endtask

    task automatic random_burst(int count, int max_sz);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 40) send_op(ffga_pkg::OP_ALLOC, 15'($urandom_range(max_sz)), 0, 0);
            else if (r < 70) free_one_live($urandom_range(9) == 0);
            else if (r < 80) send_op(ffga_pkg::OP_WRITE, 0,
                                    m_base + ($urandom_range(4200) & ~32'd3), $urandom);
            else if (r < 90) send_op(ffga_pkg::OP_READ, 0,
                                    m_base + ($urandom_range(4200) & ~32'd3), 0);
            else send_op(2'($urandom), 15'($urandom), $urandom, $urandom);
        end
    endtask

    task automatic test_config_sweep();
        logic [31:0] settings [4];
        settings = '{32'd0, 32'd8, 32'd16, 32'h7FFF};
        foreach (settings[k]) begin
            reg_write(ffga_pkg::REG_POOL_BYTES, settings[k]);
            live_blocks.delete();
            random_burst(12, 40);
            wait_drained();
        end
        reg_write(ffga_pkg::REG_POOL_BASE, 32'hFFFF_FFF8);
        reg_write(ffga_pkg::REG_POOL_BYTES, 32'd256);
        live_blocks.delete();
        random_burst(30, 40);
        wait_drained();
        reg_write(ffga_pkg::REG_POOL_BASE, 32'h0000_1000);
        random_burst(10, 40);
        wait_drained();
        reg_write(ffga_pkg::REG_POOL_BYTES, 32'd16384);
        live_blocks.delete();
        wait_drained();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 50 : 0;
            recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 36 : 0;
            random_burst(200, (phase == 2) ? 2000 : 300);
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                hold_output = 1'b1;
                for (int n = 0; n < 400; n++) @(posedge i_clk);
                hold_output = 1'b0;
            end
            random_burst(40, 64);
        join
        wait_drained();
    endtask

    initial begin
        errors        = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_output   = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_stall   = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        m_base        = 32'd0;
        m_bytes       = ffga_pkg::POOL_BYTES_RST;
        pool_rebuild();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_sweep();
        test_random_traffic();
        test_backpressure();
        if (errors == 0 && pending_beats.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
